[rtl/lcm_via_euclid_gcd_macros.svh]
// Assertion macros shared by the lcm block.
// Each macro samples on the rising edge of clk and is disabled during rst.
`ifndef LCM_VIA_EUCLID_GCD_MACROS_SVH
`define LCM_VIA_EUCLID_GCD_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define LCM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcm assertion failed");
// Next-cycle implication.
`define LCM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcm assertion failed");
`else
`define LCM_ASSERT_IMP(label, ante, cons)
`define LCM_ASSERT_NXT(label, ante, cons)
`endif

`endif

[rtl/lcm_pkg.sv]
package lcm_pkg;

  // Number of low operand bits that take part in the computation.
  localparam int OPERAND_WIDTH = 32;
  // Division step counter and common power-of-two counter widths.
  localparam int CNT_W = $clog2(OPERAND_WIDTH);
  localparam int K_W   = $clog2(OPERAND_WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL
  } state_t;

  // Result of the shared compare/subtract unit.
  typedef struct packed {
    logic [OPERAND_WIDTH:0] diff;
    logic                   ge;
  } sub_res_t;

endpackage

[rtl/lcm_via_euclid_gcd.sv]
// When either operand is zero, done is registered directly from start.
// Otherwise the item runs the GCD phase (each shift drops an operand bit, and
// a swap and a subtract may come before each shift), then the restoring
// division a/gcd one quotient bit at a time, then the multiply and result
// register. busy is high only in the GCD, division and multiply states, not
// for zero operands; done pulses one cycle, cannot be stalled; rst is synchronous.
`include "lcm_via_euclid_gcd_macros.svh"

module lcm_via_euclid_gcd (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        done,
  output logic [63:0] lcm_value,
  output logic [31:0] gcd_value
);

  localparam int W = lcm_pkg::OPERAND_WIDTH;

  lcm_pkg::state_t state, state_next;

  logic [W-1:0]              x, x_next;
  logic [W-1:0]              y, y_next;
  logic [lcm_pkg::K_W-1:0]   k, k_next;
  logic [W-1:0]              aop, aop_next;
  logic [W-1:0]              bop, bop_next;
  logic [W-1:0]              g, g_next;
  logic [W-1:0]              r, r_next;
  logic [W-1:0]              q, q_next;
  logic [lcm_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                      done_next;
  logic [63:0]               lcm_next;
  logic [31:0]               gcd_next;

  logic [W-1:0]      a_m;
  logic [W-1:0]      b_m;
  logic [W:0]        sub_lhs;
  logic [W:0]        sub_rhs;
  logic [2*W-1:0]    prod;
  lcm_pkg::sub_res_t sub_res;

  // Keep only the low operand bits.
  assign a_m = operand_a[W-1:0];
  assign b_m = operand_b[W-1:0];

  assign busy = (state != lcm_pkg::ST_IDLE);

  // Route the shared subtractor: x - y for GCD, trial remainder - g for division.
  always_comb begin
    if (state == lcm_pkg::ST_DIV) begin
      sub_lhs = {r, q[W-1]};
      sub_rhs = {1'b0, g};
    end else begin
      sub_lhs = {1'b0, x};
      sub_rhs = {1'b0, y};
    end
  end

  lcm_sub u_sub (
    .lhs (sub_lhs),
    .rhs (sub_rhs),
    .res (sub_res)
  );

  assign prod = q * bop;

  // Sequence the item through GCD, division and multiply.
  always_comb begin
    state_next = state;
    x_next     = x;
    y_next     = y;
    k_next     = k;
    aop_next   = aop;
    bop_next   = bop;
    g_next     = g;
    r_next     = r;
    q_next     = q;
    cnt_next   = cnt;
    done_next  = 1'b0;
    lcm_next   = lcm_value;
    gcd_next   = gcd_value;
    unique case (state)
      lcm_pkg::ST_IDLE: begin
        if (start) begin
          if (a_m == '0 || b_m == '0) begin
            // One operand zero: the gcd is the other one, the lcm is zero.
            gcd_next  = 32'(a_m | b_m);
            lcm_next  = '0;
            done_next = 1'b1;
          end else begin
            x_next     = a_m;
            y_next     = b_m;
            aop_next   = a_m;
            bop_next   = b_m;
            k_next     = '0;
            state_next = lcm_pkg::ST_GCD;
          end
        end
      end
      lcm_pkg::ST_GCD: begin
        priority if (x == '0) begin
          g_next     = W'(y << k);
          r_next     = '0;
          q_next     = aop;
          cnt_next   = '0;
          state_next = lcm_pkg::ST_DIV;
        end else if (y == '0) begin
          g_next     = W'(x << k);
          r_next     = '0;
          q_next     = aop;
          cnt_next   = '0;
          state_next = lcm_pkg::ST_DIV;
        end else if (!x[0] && !y[0]) begin
          // Drop a common factor of two.
          x_next = x >> 1;
          y_next = y >> 1;
          k_next = k + 1'b1;
        end else if (!x[0]) begin
          x_next = x >> 1;
        end else if (!y[0]) begin
          y_next = y >> 1;
        end else if (sub_res.ge) begin
          x_next = sub_res.diff[W-1:0];
        end else begin
          // Swap so the larger odd value is subtracted from next.
          x_next = y;
          y_next = x;
        end
      end
      lcm_pkg::ST_DIV: begin
        // Restoring division: one quotient bit of a/g per cycle.
        if (sub_res.ge) begin
          r_next = sub_res.diff[W-1:0];
        end else begin
          r_next = sub_lhs[W-1:0];
        end
        q_next   = {q[W-2:0], sub_res.ge};
        cnt_next = cnt + 1'b1;
        if (cnt == lcm_pkg::CNT_W'(W - 1)) begin
          state_next = lcm_pkg::ST_MUL;
        end
      end
      lcm_pkg::ST_MUL: begin
        // lcm = (a / g) * b
        lcm_next   = 64'(prod);
        gcd_next   = 32'(g);
        done_next  = 1'b1;
        state_next = lcm_pkg::ST_IDLE;
      end
      default: begin
        state_next = lcm_pkg::ST_IDLE;
      end
    endcase
  end

  // Reset only the control state and done; the datapath registers always load.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcm_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    x         <= x_next;
    y         <= y_next;
    k         <= k_next;
    aop       <= aop_next;
    bop       <= bop_next;
    g         <= g_next;
    r         <= r_next;
    q         <= q_next;
    cnt       <= cnt_next;
    lcm_value <= lcm_next;
    gcd_value <= gcd_next;
  end

  // Check sequencing.
  `LCM_ASSERT_IMP(a_done_not_busy, done, !busy)
  `LCM_ASSERT_NXT(a_done_single, done && !busy && !start, !done)
  `LCM_ASSERT_NXT(a_gcd_enters_div, state == lcm_pkg::ST_GCD && x == '0, cnt == '0)
  `LCM_ASSERT_NXT(a_mul_done, state == lcm_pkg::ST_MUL, done && !busy)
  `LCM_ASSERT_IMP(a_div_g_nonzero, state == lcm_pkg::ST_DIV, g != '0)

endmodule

[rtl/lcm_sub.sv]
// Shared compare/subtract unit: difference and greater-or-equal flag.
module lcm_sub (
  input  logic [lcm_pkg::OPERAND_WIDTH:0] lhs,
  input  logic [lcm_pkg::OPERAND_WIDTH:0] rhs,
  output lcm_pkg::sub_res_t               res
);

  logic [lcm_pkg::OPERAND_WIDTH+1:0] wide;

  // Subtract with one extra bit to catch the borrow.
  assign wide     = {1'b0, lhs} - {1'b0, rhs};
  assign res.diff = wide[lcm_pkg::OPERAND_WIDTH:0];
  assign res.ge   = ~wide[lcm_pkg::OPERAND_WIDTH+1];

endmodule
